/* design/max_heap_priority_queue_defines.svh */
// Assertion helpers for the heap queue module.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MHPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mhpq_pkg.sv */
package mhpq_pkg;

    // Storage geometry.
    localparam int CAPACITY = 64;
    localparam int TAG_BITS = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // Child indices reach 2 * CAPACITY, so they need two bits over the address.
    localparam int CH_W     = ADDR_W + 2;

    // Fixed field widths of the transfer ports.
    localparam int PRIO_W   = 32;
    localparam int TAG_W    = 16;
    localparam int CNT_OUT_W = 7;

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Status codes.
    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    // One stored heap entry.
    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [TAG_BITS-1:0]      tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Request transfer.
    typedef struct packed {
        logic                     operation;
        logic signed [PRIO_W-1:0] priority_req;
        logic [TAG_W-1:0]         tag;
    } t_req;

    // Result transfer.
    typedef struct packed {
        logic signed [PRIO_W-1:0] top_priority;
        logic [TAG_W-1:0]         top_tag;
        logic [CNT_OUT_W-1:0]     entry_count;
        logic                     is_empty;
        t_status                  status;
    } t_rsp;

endpackage

/* design/mhpq_ram.sv */
module mhpq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two read ports with registered data.
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

/* design/max_heap_priority_queue.sv */
// Binary max-heap priority queue of CAPACITY entries (signed priority plus tag).
// Request channel: present i_req and raise start; the request is taken at a
// clock edge where start is high and busy is low. operation selects insert or
// delete of the maximum entry; priority and tag are ignored on delete.
// Result channel: o_done is high for exactly one cycle with o_rsp valid in that
// cycle; the receiver cannot hold it off, so it must take every result.
// o_rsp gives the root entry after the operation, the entry count, an empty
// flag and a status (full insert dropped, delete on an empty heap).
// Sequence: an insert into an empty heap, an insert dropped when full, a
// delete on an empty heap and a delete of the last entry go straight to
// S_DONE. Any other insert climbs in S_UP; any other delete loads the last
// entry in S_DN_LOAD and then descends in S_DN_CMP. The sift walks one tree
// level per cycle through the two-read, one-write entry memory, so a level
// costs one read-compare-write step. busy drops in the cycle after o_done; a
// new request is taken only once the last one is through.
// Reset (synchronous, active low) empties the heap; the entry memory itself is
// not cleared, as only entries below the count are ever read.
`include "max_heap_priority_queue_defines.svh"

module max_heap_priority_queue import mhpq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_UP      = 5'b00010,
        S_DN_LOAD = 5'b00100,
        S_DN_CMP  = 5'b01000,
        S_DONE    = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]  r_pos, n_pos;
    t_entry             r_cur, n_cur;
    t_entry             r_root;
    t_status            r_status, n_status;

    // Memory port signals.
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    t_entry             w_wdata;
    logic [ADDR_W-1:0]  w_ra, w_rb;
    t_entry             w_rd_a, w_rd_b;

    // Index arithmetic.
    logic [ADDR_W-1:0]  w_parent, w_gparent, w_ins_parent, w_child;
    logic [CH_W-1:0]    w_lc, w_rc, w_cnt_ext;
    logic [ADDR_W:0]    w_child_lc;

    // Sift-down choice.
    t_entry             w_pick;
    logic               w_pick_l, w_pick_r;

    mhpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_ra),
        .i_raddr_b (w_rb),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    assign busy = (r_state != S_IDLE);

    // Parent and child positions of the hole.
    assign w_parent     = ADDR_W'((r_pos - ADDR_W'(1)) >> 1);
    assign w_gparent    = ADDR_W'((w_parent - ADDR_W'(1)) >> 1);
    assign w_ins_parent = ADDR_W'((r_count - CNT_W'(1)) >> 1);
    assign w_lc         = CH_W'({r_pos, 1'b1});
    assign w_rc         = w_lc + CH_W'(1);
    assign w_cnt_ext    = CH_W'(r_count);

    // Pick the right child if larger than the moving entry, then the left if larger still.
    always_comb begin
        w_pick   = r_cur;
        w_pick_r = 1'b0;
        w_pick_l = 1'b0;
        if ((w_rc < w_cnt_ext) && (r_cur.prio < w_rd_b.prio)) begin
            w_pick   = w_rd_b;
            w_pick_r = 1'b1;
        end
        if ((w_lc < w_cnt_ext) && (w_pick.prio < w_rd_a.prio)) begin
            w_pick   = w_rd_a;
            w_pick_l = 1'b1;
            w_pick_r = 1'b0;
        end
    end

    assign w_child    = w_pick_l ? ADDR_W'(w_lc) : ADDR_W'(w_rc);
    assign w_child_lc = {w_child, 1'b1};

    // Sequencer: the moving entry stays in r_cur and the hole at r_pos walks the tree.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pos    = r_pos;
        n_cur    = r_cur;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_pos;
        w_wdata  = r_cur;
        w_ra     = '0;
        w_rb     = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_status = ST_OK;
                    if (i_req.operation == OP_INSERT) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_cur.prio = i_req.priority_req;
                            n_cur.tag  = TAG_BITS'(i_req.tag);
                            n_pos      = ADDR_W'(r_count);
                            n_count    = r_count + CNT_W'(1);
                            if (r_count == '0) begin
                                w_we    = 1'b1;
                                w_waddr = '0;
                                w_wdata = n_cur;
                                n_state = S_DONE;
                            end else begin
                                w_ra    = w_ins_parent;
                                n_state = S_UP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_count = r_count - CNT_W'(1);
                            if (r_count == CNT_W'(1)) begin
                                n_state = S_DONE;
                            end else begin
                                w_ra    = ADDR_W'(r_count - CNT_W'(1));
                                n_state = S_DN_LOAD;
                            end
                        end
                    end
                end
            end
            S_UP: begin
                w_we = 1'b1;
                if (r_pos == '0) begin
                    n_state = S_DONE;
                end else if (r_cur.prio > w_rd_a.prio) begin
                    // Parent moves down into the hole; the hole climbs.
                    w_wdata = w_rd_a;
                    n_pos   = w_parent;
                    w_ra    = w_gparent;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DN_LOAD: begin
                // Last entry becomes the moving entry; the hole starts at the root.
                n_cur   = w_rd_a;
                n_pos   = '0;
                w_ra    = ADDR_W'(1);
                w_rb    = ADDR_W'(2);
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                w_we = 1'b1;
                if (w_pick_l || w_pick_r) begin
                    // Larger child moves up into the hole; the hole descends.
                    w_wdata = w_pick;
                    n_pos   = w_child;
                    w_ra    = ADDR_W'(w_child_lc);
                    w_rb    = ADDR_W'(w_child_lc + (ADDR_W + 1)'(1));
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    // Working entry, hole position and a copy of the root for the result.
    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_cur <= n_cur;
        if (w_we && (w_waddr == '0)) begin
            r_root <= w_wdata;
        end
    end

    // Result transfer.
    assign o_done                = (r_state == S_DONE);
    assign o_rsp.top_priority    = (r_count != '0) ? r_root.prio : '0;
    assign o_rsp.top_tag         = (r_count != '0) ? TAG_W'(r_root.tag) : '0;
    assign o_rsp.entry_count     = CNT_OUT_W'(r_count);
    assign o_rsp.is_empty        = (r_count == '0);
    assign o_rsp.status          = r_status;

    // Every memory write lands inside the filled part of the heap.
    `MHPQ_ASSERT_NOW(a_write_in_fill, i_clk, i_rst_n, w_we,
        CNT_W'(w_waddr) < n_count, "write beyond fill count")
    // An accepted request keeps the block busy in the following cycle.
    `MHPQ_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy,
        "accepted request not held")
    // A dropped insert is reported only with the heap full.
    `MHPQ_ASSERT_NOW(a_full_status, i_clk, i_rst_n, o_done && (o_rsp.status == ST_FULL),
        r_count == CNT_W'(CAPACITY), "full status with room left")
    // A delete on an empty heap leaves it empty.
    `MHPQ_ASSERT_NOW(a_empty_status, i_clk, i_rst_n, o_done && (o_rsp.status == ST_EMPTY),
        o_rsp.is_empty, "empty status with entries held")

endmodule
